/* sv/rodv_pkg.sv */
// ----------------------------------------------------------------------------
// rodv_pkg
// Shared types and constants for the recency-ordered distinct value store.
// ----------------------------------------------------------------------------
package rodv_pkg;

    // value field width and default number of cells
    localparam int VALUE_W       = 30;
    localparam int DEPTH_DEFAULT = 64;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_DUMP = 1'b1;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } state_t;

    // commands from the controller to every cell
    typedef struct packed {
        logic push_en;
        logic shift_en;
    } chain_ctl_t;

endpackage

/* sv/rodv_cell.sv */
// ----------------------------------------------------------------------------
// rodv_cell
// One slot of the recency chain: holds a value and its valid bit, compares
// against a pushed value and shifts toward the head on a hit or a dump.
// ----------------------------------------------------------------------------
module rodv_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rodv_pkg::chain_ctl_t             ctl,
    input  logic [rodv_pkg::VALUE_W-1:0]     push_value,
    input  logic                             any_hit,
    input  logic                             hit_prefix_in,
    input  logic                             left_valid,
    input  logic [rodv_pkg::VALUE_W-1:0]     right_key,
    input  logic                             right_valid,
    output logic                             hit_prefix_out,
    output logic                             match,
    output logic [rodv_pkg::VALUE_W-1:0]     key,
    output logic                             valid
);

    logic [rodv_pkg::VALUE_W-1:0] key_reg;
    logic [rodv_pkg::VALUE_W-1:0] key_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         shift_here;

    // compare and hit propagation toward the tail
    assign match          = valid_reg && (key_reg == push_value);
    assign shift_here     = hit_prefix_in || match;
    assign hit_prefix_out = shift_here;

    // next value of the slot
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctl.shift_en)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
        else if (ctl.push_en)
        begin
            if (any_hit)
            begin
                // hit: slots from the hit onward move up, the tail takes the value
                if (valid_reg && shift_here)
                begin
                    key_next = right_valid ? right_key : push_value;
                end
            end
            else if (!valid_reg && left_valid)
            begin
                // miss: first free slot appends the value
                key_next   = push_value;
                valid_next = 1'b1;
            end
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stored value
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

/* sv/rodv_ctrl.sv */
// ----------------------------------------------------------------------------
// rodv_ctrl
// Input handshake, dump sequencer, sticky overflow flag and output register.
// ----------------------------------------------------------------------------
module rodv_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic                             any_hit,
    input  logic                             full,
    input  logic [rodv_pkg::VALUE_W-1:0]     head_key,
    input  logic                             head_valid,
    input  logic                             second_valid,
    output rodv_pkg::chain_ctl_t             ctl,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rodv_pkg::VALUE_W-1:0]     out_value,
    output logic                             last_flag,
    output logic                             empty_flag,
    output logic                             overflow_flag
);

    rodv_pkg::state_t             state_reg;
    rodv_pkg::state_t             state_next;
    logic                         ovf_seen_reg;
    logic                         ovf_seen_next;
    logic                         dump_ovf_reg;
    logic                         dump_ovf_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [rodv_pkg::VALUE_W-1:0] out_value_reg;
    logic [rodv_pkg::VALUE_W-1:0] out_value_next;
    logic                         last_reg;
    logic                         last_next;
    logic                         empty_reg;
    logic                         empty_next;
    logic                         ovf_out_reg;
    logic                         ovf_out_next;
    logic                         accept;
    logic                         slot_free;
    logic                         load;

    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;

    // next state, chain commands and output register loading
    always_comb
    begin
        state_next     = state_reg;
        ovf_seen_next  = ovf_seen_reg;
        dump_ovf_next  = dump_ovf_reg;
        out_value_next = out_value_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        ovf_out_next   = ovf_out_reg;
        in_ready       = 1'b0;
        load           = 1'b0;
        ctl.push_en    = 1'b0;
        ctl.shift_en   = 1'b0;
        case (state_reg)
            rodv_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (operation == rodv_pkg::OP_DUMP)
                    begin
                        dump_ovf_next = ovf_seen_reg;
                        ovf_seen_next = 1'b0;
                        state_next    = rodv_pkg::ST_DUMP;
                    end
                    else
                    begin
                        ctl.push_en = 1'b1;
                        if (!any_hit && full)
                        begin
                            ovf_seen_next = 1'b1;
                        end
                    end
                end
            end
            rodv_pkg::ST_DUMP:
            begin
                if (slot_free)
                begin
                    load           = 1'b1;
                    ctl.shift_en   = head_valid;
                    out_value_next = head_valid ? head_key : '0;
                    last_next      = !head_valid || !second_valid;
                    empty_next     = !head_valid;
                    ovf_out_next   = dump_ovf_reg;
                    if (!head_valid || !second_valid)
                    begin
                        state_next = rodv_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = rodv_pkg::ST_IDLE;
            end
        endcase
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rodv_pkg::ST_IDLE;
            ovf_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_seen_reg  <= ovf_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dump_ovf_reg  <= dump_ovf_next;
        out_value_reg <= out_value_next;
        last_reg      <= last_next;
        empty_reg     <= empty_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign last_flag     = last_reg;
    assign empty_flag    = empty_reg;
    assign overflow_flag = ovf_out_reg;

`ifndef SYNTHESIS
    // an empty result is always the final one
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && empty_reg) |-> last_reg)
        else $error("empty result not marked last");

    // a push and a dump shift never drive the chain together
    a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.push_en && ctl.shift_en))
        else $error("push and shift at once");

    // an accepted dump starts streaming with the overflow flag cleared
    a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == rodv_pkg::OP_DUMP) |=>
            (state_reg == rodv_pkg::ST_DUMP && !ovf_seen_reg))
        else $error("dump did not start cleanly");

    // loading the final result returns to idle
    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_next) |=> (state_reg == rodv_pkg::ST_IDLE && last_reg))
        else $error("dump did not end on last result");
`endif

endmodule

/* sv/recency_order_distinct_values_top.sv */
// ----------------------------------------------------------------------------
// recency_order_distinct_values_top
// Recency stack of distinct values built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): operation 0 pushes item_value, 1 dumps.
// On a push every cell compares against the value at once; on
// a hit the slots from the hit onward shift one place toward the head and the
// tail takes the value, on a miss the first free cell appends it. With all
// DEPTH cells in use a new value is dropped and overflow is recorded for
// the overflow flag of a later dump. A push produces no item on the output
// channel, and pushes sustain one per cycle while no dump is in progress.
// A dump streams the stored values head first, one output item per cycle while
// the receiver is ready, by shifting the whole chain toward cell 0; in_ready is
// low during the dump. A dump of n values gives n items (one for an empty
// store); an accepted dump moves the controller to the dump state, which then
// loads the first item into the output register. The output register holds an
// item until out_ready; a stalled receiver simply pauses the chain shift.
// Pushes are still taken while the final item of a dump waits. Reset empties
// every cell and clears the sticky overflow record; no clearing pass is needed.
// ----------------------------------------------------------------------------
module recency_order_distinct_values_top #(
    parameter int DEPTH = rodv_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [rodv_pkg::VALUE_W-1:0]     item_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rodv_pkg::VALUE_W-1:0]     out_value,
    output logic                             last_flag,
    output logic                             empty_flag,
    output logic                             overflow_flag
);

    rodv_pkg::chain_ctl_t         ctl;
    logic [rodv_pkg::VALUE_W-1:0] key_w [DEPTH];
    logic [DEPTH-1:0]             valid_w;
    logic [DEPTH-1:0]             match_w;
    logic [DEPTH:0]               hitp_w;

    assign hitp_w[0] = 1'b0;

    // row of cells, cell 0 holds the oldest value
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [rodv_pkg::VALUE_W-1:0] right_key;
        logic                         right_valid;
        logic                         left_valid;

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_key   = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_mid
            assign right_key   = key_w[i+1];
            assign right_valid = valid_w[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_valid = valid_w[i-1];
        end

        rodv_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .push_value     (item_value),
            .any_hit        (hitp_w[DEPTH]),
            .hit_prefix_in  (hitp_w[i]),
            .left_valid     (left_valid),
            .right_key      (right_key),
            .right_valid    (right_valid),
            .hit_prefix_out (hitp_w[i+1]),
            .match          (match_w[i]),
            .key            (key_w[i]),
            .valid          (valid_w[i])
        );
    end

    // handshake, dump sequencing and output register
    rodv_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .any_hit       (hitp_w[DEPTH]),
        .full          (valid_w[DEPTH-1]),
        .head_key      (key_w[0]),
        .head_valid    (valid_w[0]),
        .second_valid  (valid_w[1]),
        .ctl           (ctl),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .last_flag     (last_flag),
        .empty_flag    (empty_flag),
        .overflow_flag (overflow_flag)
    );

`ifndef SYNTHESIS
    // stored values are distinct, so at most one cell matches
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_en |-> $onehot0(match_w))
        else $error("more than one cell matched");

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_w + {{(DEPTH-1){1'b0}}, 1'b1}) & valid_w) == '0)
        else $error("valid cells not contiguous from the head");
`endif

endmodule

/* test/tb_recency_order_distinct_values_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_recency_order_distinct_values_top
// Self-checking bench for the recency stack of distinct values. A queue of
// push and dump items feeds a bursty driver. A behavioral recency list
// predicts the stream each dump should produce, and a monitor checks every
// output item against it while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_recency_order_distinct_values_top;

    localparam int STORE_DEPTH       = rodv_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS      = 180;
    localparam int LONG_HOLD_AFTER   = 20;
    localparam int LONG_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int END_SETTLE_CYCLES = 16;
    localparam logic [rodv_pkg::VALUE_W-1:0] VALUE_MAX = '1;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_MOSTLY,
        RX_CHOPPY
    } rx_mode_t;

    typedef struct {
        logic                         op;
        logic [rodv_pkg::VALUE_W-1:0] value;
        bit                           wait_drain;
    } stim_item_t;

    typedef struct {
        logic [rodv_pkg::VALUE_W-1:0] value;
        logic                         last;
        logic                         empty;
        logic                         overflow;
    } dump_result_t;

    logic                         clk        = 1'b0;
    logic                         rst_n      = 1'b0;
    logic                         in_valid   = 1'b0;
    logic                         in_ready;
    logic                         operation  = rodv_pkg::OP_PUSH;
    logic [rodv_pkg::VALUE_W-1:0] item_value = '0;
    logic                         out_valid;
    logic                         out_ready  = 1'b0;
    logic [rodv_pkg::VALUE_W-1:0] out_value;
    logic                         last_flag;
    logic                         empty_flag;
    logic                         overflow_flag;

    // stimulus and prediction state
    stim_item_t                   pending_items[$];
    stim_item_t                   next_item;
    dump_result_t                 dump_results_due[$];
    logic [rodv_pkg::VALUE_W-1:0] recency_list[$];
    logic                         overflow_seen = 1'b0;
    int                           total_items = 0;
    int                           items_taken = 0;
    int                           results_predicted = 0;
    int                           results_checked = 0;
    int                           error_count = 0;

    // driver pacing
    int                           burst_left = 0;
    int                           gap_left = 0;

    // receiver pacing
    rx_mode_t                     stall_mode = RX_STREAM;
    int                           mode_left = 0;
    int                           hold_left = 0;
    bit                           long_hold_done = 1'b0;

    int                           idle_cycles = 0;

    recency_order_distinct_values_top #(
        .DEPTH(STORE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .item_value    (item_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_value     (out_value),
        .last_flag     (last_flag),
        .empty_flag    (empty_flag),
        .overflow_flag (overflow_flag)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [rodv_pkg::VALUE_W-1:0] rand_value();
        logic [rodv_pkg::VALUE_W-1:0] v;
        v = rodv_pkg::VALUE_W'($urandom);
        return v;
    endfunction

    task automatic queue_item(input logic op, input logic [rodv_pkg::VALUE_W-1:0] value,
                              input bit wait_drain);
        stim_item_t it;
        it.op         = op;
        it.value      = value;
        it.wait_drain = wait_drain;
        pending_items = {pending_items, it};
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        error_count++;
    endtask

    // recency list update and dump stream prediction for one accepted item
    task automatic track_recency(input logic op, input logic [rodv_pkg::VALUE_W-1:0] value);
        int           hit;
        int           n;
        dump_result_t r;
        hit = -1;
        if (op == rodv_pkg::OP_PUSH)
        begin
            foreach (recency_list[i])
                if (recency_list[i] == value)
                    hit = i;
            if (hit >= 0)
            begin
                // already held: move to newest end
                recency_list.delete(hit);
                recency_list = {recency_list, value};
            end
            else if (recency_list.size() >= STORE_DEPTH)
                overflow_seen = 1'b1;
            else
                recency_list = {recency_list, value};
        end
        else
        begin
            n = recency_list.size();
            if (n == 0)
            begin
                // empty store gives a single marker item
                r.value    = '0;
                r.last     = 1'b1;
                r.empty    = 1'b1;
                r.overflow = overflow_seen;
                dump_results_due = {dump_results_due, r};
                results_predicted++;
            end
            else
            begin
                foreach (recency_list[i])
                begin
                    r.value    = recency_list[i];
                    r.last     = (i == n - 1);
                    r.empty    = 1'b0;
                    r.overflow = overflow_seen;
                    dump_results_due = {dump_results_due, r};
                    results_predicted++;
                end
            end
            recency_list.delete();
            overflow_seen = 1'b0;
        end
    endtask

    // driver: bursts of items with random gaps, optional pause for drain
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            operation  <= rodv_pkg::OP_PUSH;
            item_value <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                track_recency(operation, item_value);
                items_taken <= items_taken + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0 &&
                         (!pending_items[0].wait_drain ||
                          results_predicted == results_checked))
                begin
                    next_item  = pending_items.pop_front();
                    in_valid   <= 1'b1;
                    operation  <= next_item.op;
                    item_value <= next_item.value;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        // occasional long stretch with no gaps
                        burst_left <= ($urandom_range(0, 3) == 0) ? 60
                                                                  : $urandom_range(1, 12);
                        gap_left   <= $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            stall_mode     <= RX_STREAM;
            mode_left      <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end
        else if (!long_hold_done && results_checked >= LONG_HOLD_AFTER)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            out_ready      <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= rx_mode_t'($urandom_range(0, 2));
                mode_left  <= $urandom_range(8, 40);
            end
            else
                mode_left <= mode_left - 1;
            case (stall_mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                default:   out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor: each output item against the oldest predicted one
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (dump_results_due.size() == 0)
                report_mismatch("item with nothing predicted", out_value, 0);
            else
            begin
                if (out_value !== dump_results_due[0].value)
                    report_mismatch("out_value", out_value, dump_results_due[0].value);
                if (last_flag !== dump_results_due[0].last)
                    report_mismatch("last_flag", last_flag, dump_results_due[0].last);
                if (empty_flag !== dump_results_due[0].empty)
                    report_mismatch("empty_flag", empty_flag, dump_results_due[0].empty);
                if (overflow_flag !== dump_results_due[0].overflow)
                    report_mismatch("overflow_flag", overflow_flag,
                                    dump_results_due[0].overflow);
                void'(dump_results_due.pop_front());
            end
            results_checked <= results_checked + 1;
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        logic [rodv_pkg::VALUE_W-1:0] pool[6];
        logic [rodv_pkg::VALUE_W-1:0] v;
        int                           kind;
        int                           n;
        int                           random_count;

        // directed: extremes, moves, ignored value on dump, empty dumps
        queue_item(rodv_pkg::OP_DUMP, '0, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, '0, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, VALUE_MAX, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, '0, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, '0, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, VALUE_MAX, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, 30'h2AAAAAAA, 1'b1);
        queue_item(rodv_pkg::OP_PUSH, 30'h2AAAAAAA, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, 30'h15555555, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, 30'h00000001, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, 30'h2AAAAAAA, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, 30'h00000001, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, 30'h15555555, 1'b0);
        queue_item(rodv_pkg::OP_PUSH, VALUE_MAX, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, '0, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, '0, 1'b0);
        queue_item(rodv_pkg::OP_DUMP, VALUE_MAX, 1'b0);

        // full store: fill, drop new values, move one while full, dump
        random_count = pending_items.size();
        for (int k = 0; k < STORE_DEPTH; k++)
        begin
            v      = rand_value();
            v[5:0] = k[5:0];
            if (k == 9)
                pool[0] = v;
            queue_item(rodv_pkg::OP_PUSH, v, k == 0);
            random_count++;
        end
        for (int k = 0; k < 3; k++)
        begin
            queue_item(rodv_pkg::OP_PUSH, rand_value(), 1'b0);
            random_count++;
        end
        queue_item(rodv_pkg::OP_PUSH, pool[0], 1'b0);
        queue_item(rodv_pkg::OP_PUSH, rand_value(), 1'b0);
        queue_item(rodv_pkg::OP_DUMP, rand_value(), 1'b0);
        random_count += 3;

        // random sequences, mostly well formed
        while (random_count < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 15);
            if (kind <= 11)
            begin
                // pushes from a small pool so values repeat, then a dump
                foreach (pool[i])
                    pool[i] = rand_value();
                n = $urandom_range(1, 14);
                for (int k = 0; k < n; k++)
                begin
                    v = ($urandom_range(0, 4) == 0) ? rand_value()
                                                    : pool[$urandom_range(0, 5)];
                    queue_item(rodv_pkg::OP_PUSH, v, k == 0 && $urandom_range(0, 7) == 0);
                end
                queue_item(rodv_pkg::OP_DUMP, rand_value(), 1'b0);
                random_count += n + 1;
            end
            else if (kind <= 14)
            begin
                // noise: any operation, any value
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    queue_item(logic'($urandom_range(0, 1)), rand_value(), 1'b0);
                random_count += n;
            end
            else
            begin
                // fill around the capacity boundary
                n = $urandom_range(STORE_DEPTH - 3, STORE_DEPTH + 4);
                for (int k = 0; k < n; k++)
                begin
                    v = rand_value();
                    if (k < STORE_DEPTH)
                        v[5:0] = k[5:0];
                    queue_item(rodv_pkg::OP_PUSH, v, 1'b0);
                end
                queue_item(rodv_pkg::OP_DUMP, rand_value(), 1'b0);
                random_count += n + 1;
            end
        end
        total_items = pending_items.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (items_taken != total_items)
            @(posedge clk);
        while (dump_results_due.size() != 0)
            @(posedge clk);
        repeat (END_SETTLE_CYCLES) @(posedge clk);

        if (dump_results_due.size() != 0)
            report_mismatch("predicted items never seen", dump_results_due.size(), 0);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
